// ===== rtl/ata_pkg.sv =====
// ---------------------------------------------------------------------------
// ata_pkg: shared types and constants of the affine transform accumulator
// Holds command codes, sequencer states, CORDIC constants and helpers.
// ---------------------------------------------------------------------------
package ata_pkg;

	localparam int CordicSteps = 16;
	localparam int StepW = $clog2(CordicSteps + 1);

	localparam logic signed [31:0] OneQ16 = 32'sd65536;
	localparam logic signed [33:0] GainQ30 = 34'sd652032874;
	localparam logic signed [33:0] PiQ30 = 34'sd3373259426;
	localparam logic signed [33:0] HalfPiQ30 = 34'sd1686629713;

	typedef enum logic [2:0] {
		FUNC_FILL = 3'd0,
		FUNC_DIAG = 3'd1,
		FUNC_SCALE = 3'd2,
		FUNC_TRANS = 3'd3,
		FUNC_ROT = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_MAC,
		ST_WRITE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	} mat_t;

	// Arctangent table in Q2.30, one entry per CORDIC step.
	function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0: v = 32'h3243F6A8;  5'd1: v = 32'h1DAC6705;
			5'd2: v = 32'h0FADBAFC;  5'd3: v = 32'h07F56EA6;
			5'd4: v = 32'h03FEAB76;  5'd5: v = 32'h01FFD55B;
			5'd6: v = 32'h00FFFAAA;  5'd7: v = 32'h007FFF55;
			5'd8: v = 32'h003FFFEA;  5'd9: v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF; 5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF; 5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF; 5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF; 5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF; 5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF; 5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF; 5'd23: v = 32'h0000007F;
			5'd24: v = 32'h0000003F; 5'd25: v = 32'h0000001F;
			5'd26: v = 32'h0000000F; 5'd27: v = 32'h00000007;
			5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
			default: v = 32'h0;
		endcase
		return $signed({2'b00, v});
	endfunction

endpackage

// ===== rtl/ata_if.sv =====
// ---------------------------------------------------------------------------
// ata_cmd_if / ata_mat_if: valid-ready channels of the block
// Command channel and matrix result channel.
// ---------------------------------------------------------------------------
interface ata_cmd_if;
	logic valid;
	logic ready;
	logic [2:0] func;
	logic signed [31:0] arg_a;
	logic signed [31:0] arg_b;
	logic signed [18:0] angle;
	modport source (output valid, func, arg_a, arg_b, angle, input ready);
	modport sink (input valid, func, arg_a, arg_b, angle, output ready);
endinterface

interface ata_mat_if;
	logic valid;
	logic ready;
	logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready);
endinterface

// ===== rtl/ata_cordic.sv =====
// ---------------------------------------------------------------------------
// ata_cordic: iterative rotation-mode CORDIC
// One micro-rotation per cycle; gives sine and cosine in Q16.16.
// ---------------------------------------------------------------------------
module ata_cordic (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [18:0] angle,
	output logic done,
	output logic signed [31:0] sin_q16,
	output logic signed [31:0] cos_q16
);
	import ata_pkg::*;

	logic signed [33:0] x_q, y_q, z_q;
	logic [StepW-1:0] step_q;
	logic busy_q, flip_q, done_q;
	logic signed [33:0] z0, zr, dx, dy, atn;
	logic fl;
	logic signed [34:0] xr, yr;

	// Range reduction of the start angle into -pi/2..pi/2.
	always_comb begin
		z0 = 34'(angle) <<< 14;
		zr = z0;
		fl = 1'b0;
		if (z0 > HalfPiQ30) begin
			zr = z0 - PiQ30;
			fl = 1'b1;
		end else if (z0 < -HalfPiQ30) begin
			zr = z0 + PiQ30;
			fl = 1'b1;
		end
		dx = y_q >>> step_q;
		dy = x_q >>> step_q;
		atn = atan_q30(5'(step_q));
		xr = (35'(x_q) + 35'sd8192) >>> 14;
		yr = (35'(y_q) + 35'sd8192) >>> 14;
	end

	// Step counter; done rises the cycle after the last micro-rotation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && step_q == StepW'(CordicSteps - 1);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == StepW'(CordicSteps - 1)) busy_q <= 1'b0;
			end
		end
	end

	// Micro-rotation register update.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= GainQ30;
			y_q <= '0;
			flip_q <= fl;
			z_q <= zr;
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atn;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atn;
			end
		end
	end

	// Results are small, so no saturation is reached.
	assign done = done_q;
	assign cos_q16 = flip_q ? -32'(xr) : 32'(xr);
	assign sin_q16 = flip_q ? -32'(yr) : 32'(yr);
endmodule

// ===== rtl/ata_mac.sv =====
// ---------------------------------------------------------------------------
// ata_mac: shared multiply-accumulate for one matrix entry
// Takes one 32x32 product per cycle, keeps split high and low sums.
// ---------------------------------------------------------------------------
module ata_mac (
	input  logic clk,
	input  logic clear,
	input  logic en,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [31:0] result
);
	import ata_pkg::*;

	logic signed [63:0] prod_s1;
	logic vld_s1;
	logic signed [49:0] hi_q;
	logic [17:0] lo_q;
	logic signed [50:0] tot;

	// Product register, then accumulate.
	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		vld_s1 <= en;
		if (clear) begin
			hi_q <= '0;
			lo_q <= '0;
		end else if (vld_s1) begin
			hi_q <= hi_q + 50'(prod_s1 >>> 16);
			lo_q <= lo_q + {2'b00, prod_s1[15:0]};
		end
	end

	// Final sum with saturation to 32 bits.
	always_comb begin
		tot = 51'(hi_q) + 51'({1'b0, lo_q[17:16]});
		if (tot > 51'sd2147483647) result = 32'h7FFFFFFF;
		else if (tot < -51'sd2147483648) result = 32'h80000000;
		else result = tot[31:0];
	end
endmodule

// ===== rtl/affine_transform_accumulator.sv =====
// ---------------------------------------------------------------------------
// affine_transform_accumulator: 3x3 Q16.16 homogeneous transform keeper
// Applies fill, diagonal load, scale, translate and rotate commands.
// ---------------------------------------------------------------------------
// Each command beat returns the whole matrix as one result beat. Fill,
// diagonal load and unused codes go straight to the write state before the
// result is offered. Scale and translate run the nine entries through one
// shared multiplier, each entry taking three products and then draining the
// product register and the accumulator, before the write; rotate first runs
// the 16 CORDIC steps and hands sine and cosine over to the rotation entries.
// The block takes no command until the result beat is taken.
module affine_transform_accumulator (
	input  logic clk,
	input  logic arst_n,
	ata_cmd_if.sink cmd,
	ata_mat_if.source res
);
	import ata_pkg::*;

	state_t state_q, state_d;
	logic signed [31:0] m_q [9];
	logic signed [31:0] r_q [9];
	logic signed [31:0] t_q [9];
	logic signed [31:0] t_init [9];
	logic [2:0] func_q;
	logic signed [31:0] a_q;
	logic [3:0] ent_q;
	logic [1:0] row_q, col_q;
	logic [2:0] k_q;
	logic cstart, cdone, mclear, men;
	logic signed [31:0] sin_v, cos_v, mres, ma, mb;
	logic accept;

	assign accept = cmd.valid && cmd.ready;
	assign cmd.ready = state_q == ST_IDLE;
	assign res.valid = state_q == ST_OUT;
	assign ma = t_q[4'(row_q) * 4'd3 + 4'(k_q[1:0])];
	assign mb = m_q[4'(k_q[1:0]) * 4'd3 + 4'(col_q)];

	ata_cordic u_cordic (.clk, .arst_n, .start(cstart), .angle(cmd.angle),
		.done(cdone), .sin_q16(sin_v), .cos_q16(cos_v));
	ata_mac u_mac (.clk, .clear(mclear), .en(men), .a(ma), .b(mb),
		.result(mres));

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		cstart = 1'b0;
		men = 1'b0;
		mclear = 1'b0;
		case (state_q)
			ST_IDLE: if (accept) begin
				if (cmd.func == FUNC_ROT) begin
					state_d = ST_CORDIC;
					cstart = 1'b1;
				end else if (cmd.func == FUNC_SCALE || cmd.func == FUNC_TRANS) begin
					state_d = ST_MAC;
					mclear = 1'b1;
				end else begin
					state_d = ST_WRITE;
				end
			end
			ST_CORDIC: if (cdone) begin
				state_d = ST_MAC;
				mclear = 1'b1;
			end
			ST_MAC: begin
				men = k_q < 3'd3;
				if (k_q == 3'd4) begin
					mclear = 1'b1;
					if (ent_q == 4'd8) state_d = ST_WRITE;
				end
			end
			ST_WRITE: state_d = ST_OUT;
			ST_OUT: if (res.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ent_q <= '0;
			row_q <= '0;
			col_q <= '0;
			k_q <= '0;
			for (int i = 0; i < 9; i++) m_q[i] <= (i % 4 == 0) ? OneQ16 : '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					ent_q <= '0;
					row_q <= '0;
					col_q <= '0;
					k_q <= '0;
				end
				ST_MAC: begin
					if (k_q == 3'd4) begin
						r_q[ent_q] <= mres;
						k_q <= '0;
						ent_q <= ent_q + 4'd1;
						if (col_q == 2'd2) begin
							col_q <= '0;
							row_q <= row_q + 2'd1;
						end else begin
							col_q <= col_q + 2'd1;
						end
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				ST_WRITE: begin
					case (func_q)
						FUNC_FILL: for (int i = 0; i < 9; i++) m_q[i] <= a_q;
						FUNC_DIAG: begin
							m_q[0] <= a_q;
							m_q[4] <= a_q;
							m_q[8] <= a_q;
						end
						FUNC_SCALE, FUNC_TRANS, FUNC_ROT:
							for (int i = 0; i < 9; i++) m_q[i] <= r_q[i];
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// Elementary matrix for the incoming command.
	always_comb begin
		for (int i = 0; i < 9; i++) t_init[i] = (i % 4 == 0) ? OneQ16 : '0;
		if (cmd.func == FUNC_SCALE) begin
			t_init[0] = cmd.arg_a;
			t_init[4] = cmd.arg_b;
		end else if (cmd.func == FUNC_TRANS) begin
			t_init[2] = cmd.arg_a;
			t_init[5] = cmd.arg_b;
		end
	end

	// Command capture and rotation entries.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= cmd.func;
			a_q <= cmd.arg_a;
			t_q <= t_init;
		end else if (state_q == ST_CORDIC && cdone) begin
			t_q[0] <= cos_v;
			t_q[1] <= sin_v;
			t_q[3] <= -sin_v;
			t_q[4] <= cos_v;
		end
	end

	assign res.m00 = m_q[0];
	assign res.m01 = m_q[1];
	assign res.m02 = m_q[2];
	assign res.m10 = m_q[3];
	assign res.m11 = m_q[4];
	assign res.m12 = m_q[5];
	assign res.m20 = m_q[6];
	assign res.m21 = m_q[7];
	assign res.m22 = m_q[8];
endmodule

// ===== bench/ata_tb_if.sv =====
// ---------------------------------------------------------------------------
// ata_tb_if: testbench side note for the channel interfaces
// The block's own interfaces in rtl/ata_if.sv are used as they stand; this
// file only carries a small bundle of bench-wide constants.
// ---------------------------------------------------------------------------
package ata_tb_pkg;
	localparam int NumRandomCmds = 1850;
	localparam int IdlePercent = 24;
endpackage

// ===== bench/ata_checker.sv =====
// ---------------------------------------------------------------------------
// ata_checker: matrix predictor and result scoreboard
// Watches the command and result channels, keeps its own copy of the
// transform matrix, predicts each result beat and compares it entry by entry.
// ---------------------------------------------------------------------------
module ata_checker (
	input  logic clk,
	input  logic arst_n,
	ata_cmd_if.sink cmd,
	ata_mat_if.sink res,
	output int errors,
	output int pending
);
	import ata_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [31:0] q16_t;
	typedef q16_t mat9_t [9];

	mat9_t model_mat;
	mat_t expected_mats [$];

	// Arithmetic right shift rounding toward minus infinity.
	function automatic longint floor_sh(input longint v, input int n);
		return v >>> n;
	endfunction

	function automatic q16_t clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return q16_t'(v);
	endfunction

	// Left-multiplies the held matrix by an elementary matrix.
	function automatic void premultiply(input mat9_t t);
		mat9_t nxt;
		longint p, hi, lo;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) begin
				hi = 0;
				lo = 0;
				for (int k = 0; k < 3; k++) begin
					p = longint'(t[r*3+k]) * longint'(model_mat[k*3+c]);
					hi += floor_sh(p, 16);
					lo += p & 64'hFFFF;
				end
				nxt[r*3+c] = clamp32(hi + floor_sh(lo, 16));
			end
		model_mat = nxt;
	endfunction

	// Rotation-mode CORDIC for sine and cosine of a signed Q3.16 angle.
	function automatic void cordic_sincos(input logic signed [18:0] ang,
			output q16_t s, output q16_t c);
		longint z, x, y, dx, dy;
		bit flip;
		z = longint'(ang) * 16384;
		x = longint'(GainQ30);
		y = 0;
		flip = 0;
		if (z > longint'(HalfPiQ30)) begin
			z -= longint'(PiQ30);
			flip = 1;
		end else if (z < -longint'(HalfPiQ30)) begin
			z += longint'(PiQ30);
			flip = 1;
		end
		for (int i = 0; i < CordicSteps && i < 30; i++) begin
			dx = floor_sh(y, i);
			dy = floor_sh(x, i);
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= longint'(atan_q30(i[4:0]));
			end else begin
				x += dx;
				y -= dy;
				z += longint'(atan_q30(i[4:0]));
			end
		end
		x = floor_sh(x + 8192, 14);
		y = floor_sh(y + 8192, 14);
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = clamp32(x);
		s = clamp32(y);
	endfunction

	function automatic mat_t apply_command(input logic [2:0] fn, input q16_t a,
			input q16_t b, input logic signed [18:0] ang);
		mat9_t t;
		q16_t s, c;
		mat_t m;
		t = '{OneQ16, 0, 0, 0, OneQ16, 0, 0, 0, OneQ16};
		case (fn)
			FUNC_FILL: begin
				foreach (model_mat[i]) model_mat[i] = a;
			end
			FUNC_DIAG: begin
				model_mat[0] = a;
				model_mat[4] = a;
				model_mat[8] = a;
			end
			FUNC_SCALE: begin
				t[0] = a;
				t[4] = b;
				premultiply(t);
			end
			FUNC_TRANS: begin
				t[2] = a;
				t[5] = b;
				premultiply(t);
			end
			FUNC_ROT: begin
				cordic_sincos(ang, s, c);
				t[0] = c;
				t[1] = s;
				t[3] = clamp32(-longint'(s));
				t[4] = c;
				premultiply(t);
			end
			default: begin
			end
		endcase
		m = {model_mat[0], model_mat[1], model_mat[2], model_mat[3], model_mat[4],
			model_mat[5], model_mat[6], model_mat[7], model_mat[8]};
		return m;
	endfunction

	task automatic compare_entry(input string name, input q16_t exp_v, input q16_t act_v);
		if (exp_v !== act_v) begin
			$display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name,
				exp_v, act_v);
			errors++;
		end
	endtask

	assign pending = expected_mats.size();

	// Predict on each command beat, compare on each result beat.
	always @(posedge clk or negedge arst_n) begin
		mat_t exp_m;
		if (!arst_n) begin
			model_mat = '{OneQ16, 0, 0, 0, OneQ16, 0, 0, 0, OneQ16};
			expected_mats.delete();
			errors = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_mats.size() == 0) begin
					$display("%0t: result beat with no command outstanding", $time);
					errors++;
				end else begin
					exp_m = expected_mats.pop_front();
					compare_entry("m00", exp_m.m00, res.m00);
					compare_entry("m01", exp_m.m01, res.m01);
					compare_entry("m02", exp_m.m02, res.m02);
					compare_entry("m10", exp_m.m10, res.m10);
					compare_entry("m11", exp_m.m11, res.m11);
					compare_entry("m12", exp_m.m12, res.m12);
					compare_entry("m20", exp_m.m20, res.m20);
					compare_entry("m21", exp_m.m21, res.m21);
					compare_entry("m22", exp_m.m22, res.m22);
				end
			end
			if (cmd.valid && cmd.ready)
				expected_mats.push_back(apply_command(cmd.func, cmd.arg_a, cmd.arg_b,
					cmd.angle));
		end
	end
endmodule

// ===== bench/tb.sv =====
// ---------------------------------------------------------------------------
// tb: top level of the affine transform accumulator testbench
// Drives directed and random transform commands with random idling on both
// channels; the checker predicts and compares every matrix result beat.
// ---------------------------------------------------------------------------
module tb;
	import ata_pkg::*;
	import ata_tb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic signed [18:0] AngleMax = 19'sd205887;

	logic clk = 0;
	logic arst_n = 0;
	int errors, pending;
	int cmds_sent = 0;
	int rot_sent = 0;
	bit calm = 0;

	ata_cmd_if cmd ();
	ata_mat_if res ();

	affine_transform_accumulator dut (.clk(clk), .arst_n(arst_n), .cmd(cmd), .res(res));
	ata_checker chk (.clk(clk), .arst_n(arst_n), .cmd(cmd), .res(res),
		.errors(errors), .pending(pending));

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Generous fixed ceiling on the run time for about 2000 commands.
	initial begin
		#10ms;
		$display("Simulation FAILED");
		$finish;
	end

	// The result side stalls at random except during the calm stretch.
	initial res.ready = 0;
	always @(posedge clk)
		res.ready <= calm || ($urandom_range(99) >= IdlePercent);

	// Sends one command beat, with a random idle gap first. Valid stays high
	// after the beat so that a following command can go out back to back.
	task automatic send_cmd(input logic [2:0] fn, input logic signed [31:0] a,
			input logic signed [31:0] b, input logic signed [18:0] ang);
		while (!calm && $urandom_range(99) < IdlePercent) begin
			cmd.valid <= 0;
			@(posedge clk);
		end
		cmd.valid <= 1;
		cmd.func <= fn;
		cmd.arg_a <= a;
		cmd.arg_b <= b;
		cmd.angle <= ang;
		do
			@(posedge clk);
		while (!cmd.ready);
		cmds_sent++;
		if (fn == FUNC_ROT)
			rot_sent++;
	endtask

	function automatic logic signed [31:0] rand_q16();
		case ($urandom_range(5))
			0: return $urandom();
			1: return $signed($urandom_range(131072)) - 65536;
			2: return $signed($urandom_range(1048576)) - 524288;
			3: return {$urandom_range(1) ? 32'hFFFFFFFF : 32'h0} ^ $urandom_range(3);
			default: return $signed($urandom_range(196608)) - 98304;
		endcase
	endfunction

	initial begin
		logic [2:0] fn;
		cmd.valid = 0;
		cmd.func = FUNC_FILL;
		cmd.arg_a = 0;
		cmd.arg_b = 0;
		cmd.angle = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, each command, unused codes and out-of-range angles.
		send_cmd(FUNC_SCALE, OneQ16 * 2, OneQ16 / 2, 0);
		send_cmd(FUNC_TRANS, 32'sh7FFFFFFF, 32'sh80000000, 0);
		send_cmd(FUNC_ROT, 0, 0, AngleMax);
		send_cmd(FUNC_ROT, 32'hFFFFFFFF, 32'hFFFFFFFF, -AngleMax);
		send_cmd(FUNC_ROT, 0, 0, 19'sh3FFFF);
		send_cmd(FUNC_ROT, 0, 0, 19'sh40000);
		send_cmd(FUNC_ROT, 0, 0, 19'sd102944);
		send_cmd(FUNC_ROT, 0, 0, -19'sd102944);
		send_cmd(3'd5, 32'h12345678, 32'h9ABCDEF0, 19'sh2AAAA);
		send_cmd(3'd6, 0, 0, 0);
		send_cmd(3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 19'sh7FFFF);
		send_cmd(FUNC_FILL, 32'sh7FFFFFFF, 32'hFFFFFFFF, 0);
		send_cmd(FUNC_SCALE, 32'sh7FFFFFFF, 32'sh80000000, 0);
		send_cmd(FUNC_FILL, 32'sh80000000, 0, 0);
		send_cmd(FUNC_SCALE, 32'sh80000000, 32'sh7FFFFFFF, 0);
		send_cmd(FUNC_DIAG, OneQ16, 0, 0);
		send_cmd(FUNC_FILL, 0, 0, 0);
		send_cmd(FUNC_DIAG, 32'sh80000000, 0, 0);
		send_cmd(FUNC_DIAG, OneQ16, 0, 0);
		cmd.valid <= 0;

		// Hold off until every expected result has come back.
		@(posedge clk);
		wait (pending == 0);
		repeat (3) @(posedge clk);

		// Random: mostly transform chains from a sane start, some noise.
		for (int n = 0; n < NumRandomCmds; n++) begin
			calm = (n >= 600 && n < 750);
			if (n % 40 == 0)
				send_cmd(FUNC_DIAG, OneQ16, $urandom(), 19'($urandom()));
			case ($urandom_range(19))
				0: fn = FUNC_FILL;
				1: fn = FUNC_DIAG;
				2, 3, 4, 5: fn = FUNC_SCALE;
				6, 7, 8, 9, 10: fn = FUNC_TRANS;
				11: fn = 3'(5 + $urandom_range(2));
				default: fn = FUNC_ROT;
			endcase
			send_cmd(fn, rand_q16(), rand_q16(),
				($urandom_range(9) == 0) ? 19'($urandom())
					: 19'($signed($urandom_range(411774)) - 205887));
		end
		cmd.valid <= 0;
		calm = 0;

		@(posedge clk);
		wait (pending == 0);
		repeat (100) @(posedge clk);
		$display("Covered %0d commands (%0d rotations), all command codes,", cmds_sent,
			rot_sent);
		$display("saturating products and wrapped angles, with random stalls.");
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
